FILE: src/s2a_pkg.sv
// Shared types, constants and key tables for the scan code to ASCII decoder.
package s2a_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int NUM_CURSOR = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_UP    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_LEFT  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_RIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_DOWN  = 8'd3;

  localparam logic [7:0] CURSOR_UP_RST    = 8'd128;
  localparam logic [7:0] CURSOR_LEFT_RST  = 8'd129;
  localparam logic [7:0] CURSOR_RIGHT_RST = 8'd130;
  localparam logic [7:0] CURSOR_DOWN_RST  = 8'd131;

  // Raw byte and key codes.
  localparam logic [7:0] BYTE_PREFIX_E0 = 8'hE0;
  localparam logic [6:0] KEY_LSHIFT     = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT     = 7'h36;
  localparam logic [6:0] KEY_CTRL       = 7'h1D;
  localparam logic [6:0] KEY_ALT        = 7'h38;
  localparam logic [6:0] KEY_CAPS       = 7'h3A;
  localparam logic [6:0] KEY_CURSOR_UP    = 7'h57;
  localparam logic [6:0] KEY_CURSOR_LEFT  = 7'h47;
  localparam logic [6:0] KEY_CURSOR_RIGHT = 7'h48;
  localparam logic [6:0] KEY_CURSOR_DOWN  = 7'h4B;
  localparam logic [6:0] TABLE_LEN        = 7'd58;

  localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;

  // Modifier flag bit positions.
  localparam int FLG_LSHIFT = 0;
  localparam int FLG_RSHIFT = 1;
  localparam int FLG_LCTRL  = 2;
  localparam int FLG_RCTRL  = 3;
  localparam int FLG_LALT   = 4;
  localparam int FLG_RALT   = 5;
  localparam int FLG_CAPS   = 6;
  localparam int FLG_EXT    = 7;

  typedef logic [NUM_CURSOR-1:0][7:0] cursor_codes_t;

  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
    logic [7:0] flags_nxt;
  } decode_res_t;

  function automatic logic [7:0] plain_map(input logic [5:0] key);
    logic [7:0] c;
    case (key)
      6'd1:  c = 8'h1B;
      6'd2:  c = "1";
      6'd3:  c = "2";
      6'd4:  c = "3";
      6'd5:  c = "4";
      6'd6:  c = "5";
      6'd7:  c = "6";
      6'd8:  c = "7";
      6'd9:  c = "8";
      6'd10: c = "9";
      6'd11: c = "0";
      6'd12: c = "-";
      6'd13: c = "=";
      6'd14: c = 8'h08;
      6'd15: c = 8'h09;
      6'd16: c = "q";
      6'd17: c = "w";
      6'd18: c = "e";
      6'd19: c = "r";
      6'd20: c = "t";
      6'd21: c = "y";
      6'd22: c = "u";
      6'd23: c = "i";
      6'd24: c = "o";
      6'd25: c = "p";
      6'd26: c = "[";
      6'd27: c = "]";
      6'd28: c = 8'h0A;
      6'd30: c = "a";
      6'd31: c = "s";
      6'd32: c = "d";
      6'd33: c = "f";
      6'd34: c = "g";
      6'd35: c = "h";
      6'd36: c = "j";
      6'd37: c = "k";
      6'd38: c = "l";
      6'd39: c = ";";
      6'd40: c = 8'h27;
      6'd41: c = 8'h60;
      6'd43: c = 8'h5C;
      6'd44: c = "z";
      6'd45: c = "x";
      6'd46: c = "c";
      6'd47: c = "v";
      6'd48: c = "b";
      6'd49: c = "n";
      6'd50: c = "m";
      6'd51: c = ",";
      6'd52: c = ".";
      6'd53: c = "/";
      6'd57: c = 8'h20;
      default: c = CHAR_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] shift_map(input logic [5:0] key);
    logic [7:0] c;
    case (key)
      6'd1:  c = 8'h1B;
      6'd2:  c = "!";
      6'd3:  c = "@";
      6'd4:  c = "#";
      6'd5:  c = "$";
      6'd6:  c = "%";
      6'd7:  c = "^";
      6'd8:  c = "&";
      6'd9:  c = "*";
      6'd10: c = "(";
      6'd11: c = ")";
      6'd12: c = "_";
      6'd13: c = "+";
      6'd14: c = 8'h08;
      6'd15: c = 8'h09;
      6'd16: c = "Q";
      6'd17: c = "W";
      6'd18: c = "E";
      6'd19: c = "R";
      6'd20: c = "T";
      6'd21: c = "Y";
      6'd22: c = "U";
      6'd23: c = "I";
      6'd24: c = "O";
      6'd25: c = "P";
      6'd26: c = "{";
      6'd27: c = "}";
      6'd28: c = 8'h0A;
      6'd30: c = "A";
      6'd31: c = "S";
      6'd32: c = "D";
      6'd33: c = "F";
      6'd34: c = "G";
      6'd35: c = "H";
      6'd36: c = "J";
      6'd37: c = "K";
      6'd38: c = "L";
      6'd39: c = ":";
      6'd40: c = 8'h22;
      6'd41: c = "~";
      6'd43: c = "|";
      6'd44: c = "Z";
      6'd45: c = "X";
      6'd46: c = "C";
      6'd47: c = "V";
      6'd48: c = "B";
      6'd49: c = "N";
      6'd50: c = "M";
      6'd51: c = "<";
      6'd52: c = ">";
      6'd57: c = 8'h20;
      default: c = CHAR_UNKNOWN;
    endcase
    return c;
  endfunction

endpackage

FILE: src/scancode_to_ascii_decoder.sv
// Top level of the scan code set 1 to ASCII decoder.
//
//   channel | ports                               | handshake
//   --------+-------------------------------------+-----------------------------
//   in      | in_scan_byte                        | in_valid / in_stall
//   out     | out_char_valid, out_char_code       | out_valid / out_stall
//   cfg     | cfg_index, cfg_wdata                | cfg_valid / cfg_ready (always 1)
//
// One word is accepted per cycle unless in_stall is high; it moves from the input
// register into the result register when the output is not stalled.
// The modifier flags update as a word moves from the input register into the
// result register, so words are decoded strictly in order.
// A stalled output holds its word; the input register still takes a word while the
// result register is empty or draining, and stalls only when both are full.
// Synchronous reset clears the flags and the pipeline valids and loads the cursor
// codes with their defaults.
module scancode_to_ascii_decoder
  import s2a_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_scan_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_char_valid,
  output logic [7:0]           out_char_code,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata
);

  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic [7:0]    flags_r;
  logic          out_valid_r;
  logic          out_char_valid_r;
  logic [7:0]    out_char_code_r;
  logic          advance;
  logic          in_take;
  cursor_codes_t cursor_codes;
  decode_res_t   dec;

  assign cfg_ready = 1'b1;

  s2a_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr_en        (cfg_valid & cfg_ready),
    .wr_index     (cfg_index),
    .wr_data      (cfg_wdata),
    .cursor_codes (cursor_codes)
  );

  s2a_decode u_dec (
    .scan_byte    (s1_byte_r),
    .flags        (flags_r),
    .cursor_codes (cursor_codes),
    .res          (dec)
  );

  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= 8'h00;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= dec.flags_nxt;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_scan_byte;
    end
    if (advance) begin
      out_char_valid_r <= dec.char_valid;
      out_char_code_r  <= dec.char_code;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_valid = out_char_valid_r;
  assign out_char_code  = out_char_code_r;

endmodule

FILE: src/s2a_cfg_regs.sv
// Cursor key code registers written through the configuration port.
module s2a_cfg_regs
  import s2a_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]           wr_data,
  output cursor_codes_t        cursor_codes
);

  cursor_codes_t codes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r[0] <= CURSOR_UP_RST;
      codes_r[1] <= CURSOR_LEFT_RST;
      codes_r[2] <= CURSOR_RIGHT_RST;
      codes_r[3] <= CURSOR_DOWN_RST;
    end else if (wr_en) begin
      // Writes to indexes past the last register are dropped.
      case (wr_index)
        REG_CURSOR_UP:    codes_r[0] <= wr_data;
        REG_CURSOR_LEFT:  codes_r[1] <= wr_data;
        REG_CURSOR_RIGHT: codes_r[2] <= wr_data;
        REG_CURSOR_DOWN:  codes_r[3] <= wr_data;
        default: ;
      endcase
    end
  end

  assign cursor_codes = codes_r;

endmodule

FILE: src/s2a_decode.sv
// Combinational decode of one scan byte against the current modifier flags.
module s2a_decode
  import s2a_pkg::*;
(
  input  logic [7:0]    scan_byte,
  input  logic [7:0]    flags,
  input  cursor_codes_t cursor_codes,
  output decode_res_t   res
);

  logic       pressed;
  logic [6:0] key;
  logic       shift_on;
  logic [7:0] plain_c;
  logic [7:0] shift_c;
  logic       is_letter;
  logic [7:0] lookup_c;

  assign pressed  = ~scan_byte[7];
  assign key      = scan_byte[6:0];
  assign shift_on = flags[FLG_LSHIFT] | flags[FLG_RSHIFT];
  assign plain_c  = plain_map(key[5:0]);
  assign shift_c  = shift_map(key[5:0]);
  assign is_letter = (plain_c >= "a") && (plain_c <= "z");

  always_comb begin
    if (key == KEY_CURSOR_UP) begin
      lookup_c = cursor_codes[0];
    end else if (key == KEY_CURSOR_LEFT) begin
      lookup_c = cursor_codes[1];
    end else if (key == KEY_CURSOR_RIGHT) begin
      lookup_c = cursor_codes[2];
    end else if (key == KEY_CURSOR_DOWN) begin
      lookup_c = cursor_codes[3];
    end else if (key >= TABLE_LEN) begin
      lookup_c = CHAR_UNKNOWN;
    end else if (is_letter) begin
      lookup_c = (shift_on ^ flags[FLG_CAPS]) ? shift_c : plain_c;
    end else begin
      lookup_c = shift_on ? shift_c : plain_c;
    end
  end

  always_comb begin
    res.char_valid = 1'b0;
    res.char_code  = 8'h00;
    res.flags_nxt  = flags;
    // The prefix is tested on the raw byte, ahead of the key checks.
    if (scan_byte == BYTE_PREFIX_E0) begin
      res.flags_nxt[FLG_EXT] = 1'b1;
    end else if (flags[FLG_EXT]) begin
      res.flags_nxt[FLG_EXT] = 1'b0;
      if (key == KEY_CTRL) begin
        res.flags_nxt[FLG_RCTRL] = pressed;
      end else if (key == KEY_ALT) begin
        res.flags_nxt[FLG_RALT] = pressed;
      end else if (pressed) begin
        res.char_valid = 1'b1;
        res.char_code  = CHAR_UNKNOWN;
      end
    end else if (key == KEY_LSHIFT) begin
      res.flags_nxt[FLG_LSHIFT] = pressed;
    end else if (key == KEY_RSHIFT) begin
      res.flags_nxt[FLG_RSHIFT] = pressed;
    end else if (key == KEY_CTRL) begin
      res.flags_nxt[FLG_LCTRL] = pressed;
    end else if (key == KEY_ALT) begin
      res.flags_nxt[FLG_LALT] = pressed;
    end else if (key == KEY_CAPS) begin
      if (pressed) begin
        res.flags_nxt[FLG_CAPS] = ~flags[FLG_CAPS];
      end
    end else if (pressed) begin
      res.char_valid = 1'b1;
      res.char_code  = lookup_c;
    end
  end

endmodule

FILE: src/s2a_checker.sv
// Port-level assertions for the decoder, bound to the top level.
module s2a_checker
  import s2a_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_char_valid,
  input logic [7:0] out_char_code
);

  // A held result keeps its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_valid) && $stable(out_char_code))
    else $error("result word changed while stalled");

  // A word without a character carries a zero code.
  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char_code == 8'h00)
    else $error("non-zero code without a character");

  // The input only stalls when the result side is full.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result register");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind scancode_to_ascii_decoder s2a_checker u_s2a_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_char_valid (out_char_valid),
  .out_char_code  (out_char_code)
);
